// ----- src/blsaw_pkg.sv -----
// shared types, constants and lane helper functions for the sparse address walker
`default_nettype none

package blsaw_pkg;

    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned OFF_W      = 24;
    localparam int unsigned MASK_W     = 4;
    // signed lane-byte index and its magnitude
    localparam int unsigned G_W        = OFF_W + 2;
    localparam int unsigned MAG_W      = G_W - 1;
    // lane count is 0..4 (0 for an empty mask), remainder below 4
    localparam int unsigned CNT_LANE_W = 3;
    localparam int unsigned DIV_STEPS  = MAG_W;
    localparam int unsigned STEP_W     = $clog2(DIV_STEPS);
    localparam logic [MASK_W-1:0] MASK_RESET = 4'hF;

    // divider control and status
    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // number of used lanes in a mask
    function automatic logic [CNT_LANE_W-1:0] count_lanes(input logic [MASK_W-1:0] m);
        logic [CNT_LANE_W-1:0] c;
        c = '0;
        for (int i = 0; i < MASK_W; i++) begin
            c = c + CNT_LANE_W'(m[i]);
        end
        return c;
    endfunction

    // used lanes strictly below low address bits lo
    function automatic logic [1:0] lanes_below(input logic [MASK_W-1:0] m,
                                               input logic [1:0] lo);
        logic [1:0] c;
        c = '0;
        for (int i = 0; i < MASK_W - 1; i++) begin
            if (i < int'(lo) && m[i]) begin
                c = c + 2'd1;
            end
        end
        return c;
    endfunction

    // lane position of the k-th used lane (0-based)
    function automatic logic [1:0] kth_lane(input logic [MASK_W-1:0] m, input logic [1:0] k);
        logic [1:0] pos;
        logic [2:0] seen;
        logic       found;
        pos   = '0;
        seen  = '0;
        found = 1'b0;
        for (int i = 0; i < MASK_W; i++) begin
            if (m[i] && !found) begin
                if (seen[1:0] == k) begin
                    pos   = 2'(i);
                    found = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ----- src/byte_lane_sparse_address_walker_core.sv -----
// top level: sequencer around the shared divider, lane mask register and output register
//
// Walks a byte address over a ROM that occupies only some byte lanes of each
// 32-bit word. The lane mask register (i_cfg_we / i_cfg_wdata) selects the used
// lanes; it resets to all four lanes and must be written only while the block is
// idle, which the block itself does not enforce. Input words (i_start_address,
// i_offset) use i_in_valid / o_in_ready; results (o_end_address) use o_out_valid /
// i_out_ready. The offset is a 24-bit two's complement count of lane bytes.
// A walk runs from acceptance through a start state, the bit-serial divider (one
// quotient bit per cycle over the 25-bit index magnitude), a state that sees the
// divider finish, a state that forms the address and the load of the output
// register. A zero offset or an empty mask skips the divider and goes straight
// to the output register load. One word is in flight at a time: a new word is
// accepted only after the walk has loaded the output register.
// The output register holds its word until taken; a new input word can be
// accepted while it waits, and the finished walk then stalls in its last state
// until the output register frees. Reset clears all control state and sets the
// lane mask to all lanes.
`default_nettype none

module byte_lane_sparse_address_walker_core
    import blsaw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [MASK_W-1:0] i_cfg_wdata,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [ADDR_W-1:0] i_start_address,
    input  wire logic [OFF_W-1:0]  i_offset,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [ADDR_W-1:0]      o_end_address
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [MASK_W-1:0]     r_lane_mask;
    logic [ADDR_W-3:0]     r_base;
    logic [G_W-1:0]        r_g;
    logic                  r_pos;
    logic [ADDR_W-1:0]     r_res;
    logic                  r_out_valid;
    logic [ADDR_W-1:0]     r_end_address;

    t_div_ctrl             w_ctrl;
    t_div_stat             w_stat;
    logic [MAG_W-1:0]      w_quo;
    logic [CNT_LANE_W-1:0] w_rem;
    logic [CNT_LANE_W-1:0] w_cnt;
    logic                  w_accept;
    logic                  w_neg_off;
    logic                  w_zero_off;
    logic [G_W-1:0]        w_len;
    logic [G_W-1:0]        w_g;
    logic                  w_neg_g;
    logic [MAG_W-1:0]      w_mag;
    logic                  w_has_rem;
    logic [G_W-1:0]        w_word;
    logic [CNT_LANE_W-1:0] w_idx;
    logic [1:0]            w_lane;
    logic [ADDR_W-1:0]     w_word_ext;
    logic [ADDR_W-1:0]     w_sum;
    logic                  w_out_free;

    assign w_cnt      = count_lanes(r_lane_mask);
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;

    // signed lane-byte index of the target or last passed byte
    assign w_neg_off  = i_offset[OFF_W-1];
    assign w_zero_off = (i_offset == '0);
    assign w_len      = {{(G_W - OFF_W){w_neg_off}}, i_offset};
    assign w_g        = w_len + G_W'(lanes_below(r_lane_mask, i_start_address[1:0]))
                      - G_W'(!w_neg_off);

    // magnitude of the index for the divider
    assign w_neg_g = r_g[G_W-1];
    assign w_mag   = w_neg_g ? MAG_W'(-r_g) : r_g[MAG_W-1:0];
    assign w_ctrl.start = (r_state == S_START);

    blsaw_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_dividend  (w_mag),
        .i_divisor   (w_cnt),
        .o_stat      (w_stat),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // floor division fix-up and address assembly
    assign w_has_rem  = (w_rem != '0);
    assign w_word     = (w_neg_g) ? G_W'(-({1'b0, w_quo} + G_W'(w_has_rem)))
                                  : {1'b0, w_quo};
    assign w_idx      = (w_neg_g && w_has_rem) ? CNT_LANE_W'(w_cnt - w_rem) : w_rem;
    assign w_lane     = kth_lane(r_lane_mask, w_idx[1:0]);
    assign w_word_ext = {{(ADDR_W - G_W){w_word[G_W-1]}}, w_word};
    assign w_sum      = {r_base, 2'b00} + {w_word_ext[ADDR_W-3:0], 2'b00}
                      + {{(ADDR_W - 2){1'b0}}, w_lane} + {{(ADDR_W - 1){1'b0}}, r_pos};

    // lane mask register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_mask <= MASK_RESET;
        end else if (i_cfg_we) begin
            r_lane_mask <= i_cfg_wdata;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= (w_zero_off || w_cnt == '0) ? S_DONE : S_START;
                    end
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_stat.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_end_address <= r_res;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // walk datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base <= i_start_address[ADDR_W-1:2];
            r_g    <= w_g;
            r_pos  <= !w_neg_off;
            r_res  <= i_start_address;
        end else if (r_state == S_FIN) begin
            r_res  <= w_sum;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_end_address = r_end_address;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_in_ready)
        else $error("input ready while a walk is in progress");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_START |=> w_stat.busy)
        else $error("divider not busy after start");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word appeared without a finished walk");

endmodule

`default_nettype wire

// ----- src/blsaw_div.sv -----
// bit-serial restoring divider of the lane-byte index by the lane count
`default_nettype none

module blsaw_div
    import blsaw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_div_ctrl             i_ctrl,
    input  wire logic [MAG_W-1:0]      i_dividend,
    input  wire logic [CNT_LANE_W-1:0] i_divisor,
    output t_div_stat                  o_stat,
    output logic [MAG_W-1:0]           o_quotient,
    output logic [CNT_LANE_W-1:0]      o_remainder
);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [MAG_W-1:0]      r_quo,  n_quo;
    logic [CNT_LANE_W-1:0] r_rem,  n_rem;
    logic [CNT_LANE_W-1:0] r_dvs,  n_dvs;
    logic [CNT_LANE_W:0]   w_trial;
    logic                  w_fits;

    // shared compare and subtract step
    assign w_trial = {r_rem, r_quo[MAG_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_dvs};

    // next state of the iteration
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_ctrl.start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[MAG_W-2:0], w_fits};
            n_rem = w_fits ? CNT_LANE_W'(w_trial - {1'b0, r_dvs})
                           : w_trial[CNT_LANE_W-1:0];
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem;

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy || r_done) && r_dvs != '0 |-> r_rem < r_dvs)
        else $error("partial remainder not below divisor");

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |=> r_busy)
        else $error("divider did not start");

endmodule

`default_nettype wire

// ----- sim/byte_lane_sparse_address_walker_core_tb.sv -----
// self-checking testbench for the sparse byte-lane address walker core
module byte_lane_sparse_address_walker_core_tb
    import blsaw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 5;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 40;
    localparam int NUM_PHASES     = 12;
    localparam int WORDS_PER_PHASE = 52;
    localparam int NUM_DIRECTED   = 22;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [ADDR_W-1:0] start;
        logic [OFF_W-1:0]  offset;
        logic              typed;
        logic [ADDR_W-1:0] end_addr;
    } t_walk_case;

    // typed rows carry their end address, the others go through the predictor
    localparam t_walk_case DIRECTED_CASES [NUM_DIRECTED] = '{
        '{4'hF, 32'h0000_0100, 24'h000000, 1'b1, 32'h0000_0100},
        '{4'hF, 32'h0000_0100, 24'h000001, 1'b1, 32'h0000_0101},
        '{4'hF, 32'h0000_0000, 24'hFFFFFF, 1'b1, 32'hFFFF_FFFF},
        '{4'hF, 32'hFFFF_FFFF, 24'h000001, 1'b1, 32'h0000_0000},
        '{4'hF, 32'h0000_0000, 24'h7FFFFF, 1'b1, 32'h007F_FFFF},
        '{4'hF, 32'h1000_0000, 24'h800000, 1'b1, 32'h0F80_0000},
        '{4'hF, 32'hFFFF_FFFF, 24'h000000, 1'b1, 32'hFFFF_FFFF},
        '{4'hF, 32'hA5A5_5A5A, 24'h5A5A5A, 1'b0, 32'h0},
        '{4'h1, 32'h0000_0000, 24'h000001, 1'b1, 32'h0000_0001},
        '{4'h1, 32'h0000_0001, 24'hFFFFFF, 1'b1, 32'h0000_0000},
        '{4'h1, 32'h0000_0010, 24'h7FFFFF, 1'b0, 32'h0},
        '{4'h1, 32'h0000_0000, 24'h800000, 1'b0, 32'h0},
        '{4'h8, 32'h0000_0000, 24'h000001, 1'b0, 32'h0},
        '{4'h8, 32'h0000_0003, 24'hFFFFFF, 1'b0, 32'h0},
        '{4'hA, 32'h8000_0002, 24'h000003, 1'b0, 32'h0},
        '{4'h5, 32'h0000_0001, 24'hFFFFFE, 1'b0, 32'h0},
        '{4'h0, 32'h0000_1234, 24'h000005, 1'b1, 32'h0000_1234},
        '{4'h0, 32'hFFFF_FFFF, 24'h800000, 1'b1, 32'hFFFF_FFFF},
        '{4'h0, 32'h0000_0000, 24'h7FFFFF, 1'b1, 32'h0000_0000},
        '{4'h7, 32'hFFFF_FFFE, 24'h000004, 1'b0, 32'h0},
        '{4'hE, 32'h0000_0001, 24'hFFFFFD, 1'b0, 32'h0},
        '{4'hF, 32'h5A5A_A5A5, 24'hA5A5A5, 1'b0, 32'h0}
    };

    localparam logic [MASK_W-1:0] PHASE_MASKS [NUM_PHASES] = '{
        4'hF, 4'h1, 4'h8, 4'h0, 4'h5, 4'hA, 4'h6, 4'h9, 4'h7, 4'hE, 4'h3, 4'hF
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [MASK_W-1:0] i_cfg_wdata;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [ADDR_W-1:0] i_start_address;
    logic [OFF_W-1:0]  i_offset;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [ADDR_W-1:0] o_end_address;

    logic [MASK_W-1:0] lane_mask_now;
    logic [ADDR_W-1:0] pending_end_addr [$];
    int                mismatch_count;
    int                quiet_cycles;
    bit                idle_en;
    bit                hold_request;

    byte_lane_sparse_address_walker_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_start_address (i_start_address),
        .i_offset        (i_offset),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_end_address   (o_end_address)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // expected end address of one walk over the used lanes
    function automatic logic [ADDR_W-1:0] walk_address(input logic [MASK_W-1:0] mask,
                                                        input logic [ADDR_W-1:0] start,
                                                        input logic [OFF_W-1:0]  raw);
        int                used;
        int                before_lo;
        int                pos;
        int                seen;
        longint            steps;
        longint            idx;
        longint            word_q;
        longint            rem;
        logic [ADDR_W-1:0] dest;
        used      = 0;
        before_lo = 0;
        for (int b = 0; b < MASK_W; b++) begin
            used += int'(mask[b]);
            if (b < int'(start[1:0]) && mask[b]) begin
                before_lo++;
            end
        end
        if (used == 0 || raw == '0) begin
            return start;
        end
        steps = {{40{raw[OFF_W-1]}}, raw};
        // forward walks land one past the last used byte passed
        idx = before_lo + steps - ((steps > 0) ? 1 : 0);
        word_q = idx / used;
        rem    = idx - word_q * used;
        if (rem < 0) begin
            rem    += used;
            word_q -= 1;
        end
        pos  = 0;
        seen = 0;
        for (int b = 0; b < MASK_W; b++) begin
            if (mask[b]) begin
                if (seen == rem) begin
                    pos = b;
                end
                seen++;
            end
        end
        dest = {start[ADDR_W-1:2], 2'b00} + ADDR_W'(word_q * 4) + ADDR_W'(pos);
        if (steps > 0) begin
            dest += 1;
        end
        return dest;
    endfunction

    function automatic logic [OFF_W-1:0] pick_offset();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                return '0;
            end
            1, 2: begin
                return OFF_W'($urandom_range(1, 16));
            end
            3, 4: begin
                return OFF_W'(-$urandom_range(1, 16));
            end
            5: begin
                return 24'h7FFFFF - OFF_W'($urandom_range(0, 15));
            end
            6: begin
                return 24'h800000 + OFF_W'($urandom_range(0, 15));
            end
            default: begin
                return OFF_W'($urandom);
            end
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        int kind;
        kind = $urandom_range(0, 5);
        case (kind)
            0: begin
                return ADDR_W'($urandom_range(0, 7));
            end
            1: begin
                return 32'hFFFF_FFFF - ADDR_W'($urandom_range(0, 7));
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // offer one word, record its end address once accepted
    task automatic send_word(input logic [ADDR_W-1:0] start, input logic [OFF_W-1:0] offset,
                             input logic [ADDR_W-1:0] end_addr);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_start_address <= start;
        i_offset        <= offset;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        pending_end_addr.push_back(end_addr);
        @(negedge i_clk);
    endtask

    // stop offering and wait for every outstanding word
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_end_addr.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_lane_mask(input logic [MASK_W-1:0] mask);
        i_cfg_we      <= 1'b1;
        i_cfg_wdata   <= mask;
        @(negedge i_clk);
        i_cfg_we      <= 1'b0;
        lane_mask_now  = mask;
    endtask

    // receiver: random stall bursts, plus one long hold on request
    initial begin
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin : check_output
        logic [ADDR_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_end_addr.size() == 0) begin
                report_mismatch($sformatf("unexpected word end_address=%h", o_end_address));
            end else begin
                want = pending_end_addr.pop_front();
                if (o_end_address !== want) begin
                    report_mismatch($sformatf("end_address got %h want %h",
                                              o_end_address, want));
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        logic [MASK_W-1:0] mask;
        logic [ADDR_W-1:0] start;
        logic [OFF_W-1:0]  offset;
        t_walk_case        row;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_in_valid      = 1'b0;
        i_start_address = '0;
        i_offset        = '0;
        mismatch_count  = 0;
        idle_en         = 1'b1;
        hold_request    = 1'b0;
        lane_mask_now   = MASK_RESET;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int r = 0; r < NUM_DIRECTED; r++) begin
            row = DIRECTED_CASES[r];
            if (row.mask != lane_mask_now) begin
                drain_results();
                write_lane_mask(row.mask);
            end
            send_word(row.start, row.offset,
                      row.typed ? row.end_addr
                                : walk_address(lane_mask_now, row.start, row.offset));
        end

        // random phases, one lane mask each
        for (int p = 0; p < NUM_PHASES; p++) begin
            mask = (p == NUM_PHASES - 2) ? MASK_W'($urandom_range(0, 15)) : PHASE_MASKS[p];
            drain_results();
            write_lane_mask(mask);
            if (p == NUM_PHASES - 1) begin
                idle_en = 1'b0;
            end
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                // long receiver hold while the sender keeps offering
                if (p == 1 && n == 10) begin
                    hold_request = 1'b1;
                end
                // sender pause until the pipe is empty
                if (p == 2 && n == 20) begin
                    drain_results();
                end
                start  = pick_address();
                offset = pick_offset();
                send_word(start, offset, walk_address(lane_mask_now, start, offset));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_end_addr.size() != 0) begin
            report_mismatch($sformatf("%0d words never arrived", pending_end_addr.size()));
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/blsaw_pkg.sv
src/blsaw_div.sv
src/byte_lane_sparse_address_walker_core.sv
sim/byte_lane_sparse_address_walker_core_tb.sv
